// File: design/tfc_pkg.sv
package tfc_pkg;

   localparam int EVQ_DEPTH_DEF = 4;
   localparam int RSP_DEPTH_DEF = 4;

   localparam logic [7:0] SYNC_I = 8'h49;
   localparam logic [7:0] SYNC_X = 8'h58;

   localparam logic [15:0] POS_VERSION    = 16'd2;
   localparam logic [15:0] POS_LEN_HI     = 16'd17;
   localparam logic [15:0] POS_LEN_LO     = 16'd18;
   localparam logic [15:0] POS_TIME_FIRST = 16'd19;
   localparam logic [15:0] POS_TIME_LAST  = 16'd22;
   localparam logic [15:0] POS_CNT_FIRST  = 16'd23;
   localparam logic [15:0] POS_CNT_LAST   = 16'd26;
   localparam logic [15:0] HDR_LEN        = 16'd27;
   localparam logic [15:0] MIN_LEN        = 16'd31;
   localparam logic [15:0] SKIP_MAX       = 16'hFFFF;

   localparam logic [7:0]  VERSION_RST  = 8'd5;
   localparam logic [31:0] STEP_MIN_RST = 32'd50;
   localparam logic [31:0] STEP_MAX_RST = 32'd51;
   localparam logic [31:0] REBOOT_RST   = 32'd100;

   typedef enum logic [1:0] {
      CSR_VERSION  = 2'd0,
      CSR_STEP_MIN = 2'd1,
      CSR_STEP_MAX = 2'd2,
      CSR_REBOOT   = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_GOOD         = 3'd0,
      ST_BAD_CHECKSUM = 3'd1,
      ST_BAD_VERSION  = 3'd2,
      ST_BAD_LENGTH   = 3'd3,
      ST_CLEAN_END    = 3'd4,
      ST_TRUNC_END    = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      CLS_IN_ORDER  = 3'd0,
      CLS_DUPLICATE = 3'd1,
      CLS_OUT_OF_SEQ = 3'd2,
      CLS_REBOOT    = 3'd3,
      CLS_GAP       = 3'd4
   } class_type;

   typedef enum logic [1:0] {
      EV_FRAME       = 2'd0,
      EV_BAD_VERSION = 2'd1,
      EV_BAD_LENGTH  = 2'd2,
      EV_END         = 2'd3
   } ev_kind_type;

   // flag: checksum matched for a frame, clean for an end of capture
   typedef struct packed {
      ev_kind_type kind;
      logic        flag;
      logic [31:0] counter;
      logic [31:0] time_val;
      logic [15:0] length;
      logic [15:0] garbage;
   } ev_type;

   typedef struct packed {
      status_type  status;
      class_type   seq_class;
      logic [31:0] counter_value;
      logic [31:0] missing_count;
      logic [31:0] time_delta;
      logic        time_irregular;
      logic [15:0] garbage_bytes;
      logic [15:0] frame_length;
      logic        all_good;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  expected_version;
      logic [31:0] time_step_min;
      logic [31:0] time_step_max;
      logic [31:0] reboot_threshold;
   } cfg_type;

endpackage

// File: design/telegram_frame_checker.sv
// Telegram frame checker: scans a byte capture for 'I','X' telegrams and
// reports one result per finished or rejected telegram and per end of capture.
// Input channel: drive req_data_byte / req_end_mark with push; a byte
// transfers on a clock edge with push high and full low. req_end_mark
// marks the end of a capture instead of a byte.
// Result channel: while empty is low the oldest result is on the rsp_
// ports; it transfers on an edge with pop high.
// Configuration: csr_index / csr_data with csr_valid; csr_ready is always
// high. Write only while no result is outstanding.
// Throughput: one byte per cycle while full is low. A result passes through the
// event queue, the classify stage and the result queue on its way to the rsp_ ports.
// When the result side stalls, the result queue fills, then the classify
// stage and the event queue; full rises only when the event queue is full,
// so bytes keep flowing for EVQ_DEPTH + RSP_DEPTH + 1 pending results.
// Reset clears the parser, sequence state and both queues and restores the
// configuration defaults; the block accepts bytes as soon as reset is released.
module telegram_frame_checker #(
   parameter int EVQ_DEPTH = tfc_pkg::EVQ_DEPTH_DEF,
   parameter int RSP_DEPTH = tfc_pkg::RSP_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_mark,
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_status,
   output logic [2:0]  rsp_seq_class,
   output logic [31:0] rsp_counter_value,
   output logic [31:0] rsp_missing_count,
   output logic [31:0] rsp_time_delta,
   output logic        rsp_time_irregular,
   output logic [15:0] rsp_garbage_bytes,
   output logic [15:0] rsp_frame_length,
   output logic        rsp_all_good,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int EV_W  = $bits(tfc_pkg::ev_type);
   localparam int RSP_W = $bits(tfc_pkg::rsp_type);

   tfc_pkg::cfg_type cfg_ff, cfg_in;

   logic             byte_valid;
   logic             front_ev_valid;
   tfc_pkg::ev_type  front_ev;
   logic [EV_W-1:0]  evq_rd_data;
   logic             evq_empty;
   logic             ev_pop;
   tfc_pkg::ev_type  back_ev;
   logic             back_rsp_valid;
   tfc_pkg::rsp_type back_rsp;
   logic             rspq_full;
   logic [RSP_W-1:0] rspq_rd_data;
   tfc_pkg::rsp_type rsp_head;

   assign csr_ready  = 1'b1;
   assign byte_valid = push & ~full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (tfc_pkg::csr_index_type'(csr_index))
            tfc_pkg::CSR_VERSION:  cfg_in.expected_version = csr_data[7:0];
            tfc_pkg::CSR_STEP_MIN: cfg_in.time_step_min    = csr_data;
            tfc_pkg::CSR_STEP_MAX: cfg_in.time_step_max    = csr_data;
            tfc_pkg::CSR_REBOOT:   cfg_in.reboot_threshold = csr_data;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_version <= tfc_pkg::VERSION_RST;
         cfg_ff.time_step_min    <= tfc_pkg::STEP_MIN_RST;
         cfg_ff.time_step_max    <= tfc_pkg::STEP_MAX_RST;
         cfg_ff.reboot_threshold <= tfc_pkg::REBOOT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tfc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .byte_valid       (byte_valid),
      .data_byte        (req_data_byte),
      .end_mark         (req_end_mark),
      .expected_version (cfg_ff.expected_version),
      .ev_valid         (front_ev_valid),
      .ev               (front_ev)
   );

   tfc_fifo #(
      .WIDTH (EV_W),
      .DEPTH (EVQ_DEPTH)
   ) u_evq (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (front_ev_valid),
      .wr_data (front_ev),
      .full    (full),
      .rd_en   (ev_pop),
      .rd_data (evq_rd_data),
      .empty   (evq_empty)
   );

   assign back_ev = tfc_pkg::ev_type'(evq_rd_data);

   tfc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .ev_valid  (~evq_empty),
      .ev        (back_ev),
      .ev_pop    (ev_pop),
      .out_ready (~rspq_full),
      .rsp_valid (back_rsp_valid),
      .rsp       (back_rsp)
   );

   tfc_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rspq (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (back_rsp_valid),
      .wr_data (back_rsp),
      .full    (rspq_full),
      .rd_en   (pop),
      .rd_data (rspq_rd_data),
      .empty   (empty)
   );

   assign rsp_head = tfc_pkg::rsp_type'(rspq_rd_data);

   assign rsp_status         = rsp_head.status;
   assign rsp_seq_class      = rsp_head.seq_class;
   assign rsp_counter_value  = rsp_head.counter_value;
   assign rsp_missing_count  = rsp_head.missing_count;
   assign rsp_time_delta     = rsp_head.time_delta;
   assign rsp_time_irregular = rsp_head.time_irregular;
   assign rsp_garbage_bytes  = rsp_head.garbage_bytes;
   assign rsp_frame_length   = rsp_head.frame_length;
   assign rsp_all_good       = rsp_head.all_good;

endmodule

// File: design/tfc_fifo.sv
module tfc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = tfc_pkg::EVQ_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             wr_ok, rd_ok;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign wr_ok = wr_en & ~full;
   assign rd_ok = rd_en & ~empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (wr_ok) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_ok) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(wr_ok) - CW'(rd_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: design/tfc_front.sv
module tfc_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            byte_valid,
   input  logic [7:0]      data_byte,
   input  logic            end_mark,
   input  logic [7:0]      expected_version,
   output logic            ev_valid,
   output tfc_pkg::ev_type ev
);

   typedef enum logic [2:0] {
      PH_HUNT  = 3'b001,
      PH_SAW_I = 3'b010,
      PH_BODY  = 3'b100
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] pos_ff, pos_in;
   logic [31:0] sum_ff, sum_in;
   logic [15:0] len_ff, len_in;
   logic [31:0] time_ff, time_in;
   logic [31:0] cnt_ff, cnt_in;
   logic [31:0] claim_ff, claim_in;
   logic [15:0] skip_ff, skip_in;

   logic [31:0] claim_shift;
   logic [15:0] len_shift;
   logic [16:0] skip_plus1, skip_plus2;
   logic [15:0] skip_one, skip_two;
   logic [16:0] pos_ext, len_ext;

   assign claim_shift = {claim_ff[23:0], data_byte};
   assign len_shift   = {len_ff[7:0], data_byte};
   assign skip_plus1  = {1'b0, skip_ff} + 17'd1;
   assign skip_plus2  = {1'b0, skip_ff} + 17'd2;
   assign skip_one    = skip_plus1[16] ? tfc_pkg::SKIP_MAX : skip_plus1[15:0];
   assign skip_two    = skip_plus2[16] ? tfc_pkg::SKIP_MAX : skip_plus2[15:0];
   assign pos_ext     = {1'b0, pos_ff};
   assign len_ext     = {1'b0, len_ff};

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      len_in   = len_ff;
      time_in  = time_ff;
      cnt_in   = cnt_ff;
      claim_in = claim_ff;
      skip_in  = skip_ff;
      ev_valid = 1'b0;
      ev       = '0;
      ev.garbage = skip_ff;
      if (byte_valid) begin
         if (end_mark) begin
            ev_valid  = 1'b1;
            ev.kind   = tfc_pkg::EV_END;
            ev.flag   = (phase_ff == PH_HUNT) && (skip_ff == '0);
            ev.length = ((phase_ff == PH_BODY) && (pos_ff > tfc_pkg::POS_LEN_LO)) ?
                        len_ff : '0;
            phase_in  = PH_HUNT;
            pos_in    = '0;
            skip_in   = '0;
         end else begin
            case (phase_ff)
               PH_HUNT: begin
                  if (data_byte == tfc_pkg::SYNC_I) begin
                     phase_in = PH_SAW_I;
                  end else begin
                     skip_in = skip_one;
                  end
               end
               PH_SAW_I: begin
                  if (data_byte == tfc_pkg::SYNC_X) begin
                     phase_in = PH_BODY;
                     pos_in   = 16'd2;
                     sum_in   = 32'(tfc_pkg::SYNC_I) + 32'(tfc_pkg::SYNC_X);
                     len_in   = '0;
                     time_in  = '0;
                     cnt_in   = '0;
                     claim_in = '0;
                  end else if (data_byte == tfc_pkg::SYNC_I) begin
                     skip_in = skip_one;
                  end else begin
                     skip_in  = skip_two;
                     phase_in = PH_HUNT;
                  end
               end
               PH_BODY: begin
                  // trailing four bytes hold the checksum claim, all others are summed
                  if ((pos_ff < tfc_pkg::HDR_LEN) || ((pos_ext + 17'd4) < len_ext)) begin
                     sum_in = sum_ff + 32'(data_byte);
                  end else begin
                     claim_in = claim_shift;
                  end
                  if ((pos_ff == tfc_pkg::POS_VERSION) && (data_byte != expected_version)) begin
                     ev_valid = 1'b1;
                     ev.kind  = tfc_pkg::EV_BAD_VERSION;
                     phase_in = PH_HUNT;
                     pos_in   = '0;
                     skip_in  = '0;
                  end else if ((pos_ff == tfc_pkg::POS_LEN_LO) &&
                               (len_shift < tfc_pkg::MIN_LEN)) begin
                     ev_valid  = 1'b1;
                     ev.kind   = tfc_pkg::EV_BAD_LENGTH;
                     ev.length = len_shift;
                     phase_in  = PH_HUNT;
                     pos_in    = '0;
                     skip_in   = '0;
                  end else if ((pos_ff >= tfc_pkg::HDR_LEN) &&
                               ((pos_ext + 17'd1) == len_ext)) begin
                     ev_valid    = 1'b1;
                     ev.kind     = tfc_pkg::EV_FRAME;
                     ev.flag     = (sum_ff == claim_shift);
                     ev.counter  = cnt_ff;
                     ev.time_val = time_ff;
                     ev.length   = len_ff;
                     phase_in    = PH_HUNT;
                     pos_in      = '0;
                     skip_in     = '0;
                  end else begin
                     pos_in = pos_ff + 16'd1;
                     if ((pos_ff == tfc_pkg::POS_LEN_HI) || (pos_ff == tfc_pkg::POS_LEN_LO)) begin
                        len_in = len_shift;
                     end
                     if ((pos_ff >= tfc_pkg::POS_TIME_FIRST) &&
                         (pos_ff <= tfc_pkg::POS_TIME_LAST)) begin
                        time_in = {time_ff[23:0], data_byte};
                     end
                     if ((pos_ff >= tfc_pkg::POS_CNT_FIRST) &&
                         (pos_ff <= tfc_pkg::POS_CNT_LAST)) begin
                        cnt_in = {cnt_ff[23:0], data_byte};
                     end
                  end
               end
               default: begin
                  phase_in = PH_HUNT;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         pos_ff   <= '0;
         skip_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         skip_ff  <= skip_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      len_ff   <= len_in;
      time_ff  <= time_in;
      cnt_ff   <= cnt_in;
      claim_ff <= claim_in;
   end

endmodule

// File: design/tfc_back.sv
module tfc_back (
   input  logic             clock,
   input  logic             reset,
   input  tfc_pkg::cfg_type cfg,
   input  logic             ev_valid,
   input  tfc_pkg::ev_type  ev,
   output logic             ev_pop,
   input  logic             out_ready,
   output logic             rsp_valid,
   output tfc_pkg::rsp_type rsp
);

   logic [31:0] prev_cnt_ff, prev_cnt_in;
   logic [31:0] prev_time_ff, prev_time_in;
   logic        seen_first_ff, seen_first_in;
   logic        perfect_ff, perfect_in;

   logic             s1_valid_ff, s1_valid_in;
   tfc_pkg::rsp_type s1_rsp_ff, s1_rsp_in;
   logic [31:0]      s1_back_ff, s1_back_in;
   logic             s1_check_ff, s1_check_in;

   logic        s1_ready;
   logic [31:0] prev_inc, fwd_miss, back_diff, dt;

   assign s1_ready = ~s1_valid_ff | out_ready;
   assign ev_pop   = ev_valid & s1_ready;

   assign prev_inc  = prev_cnt_ff + 32'd1;
   assign fwd_miss  = ev.counter - prev_inc;
   assign back_diff = prev_cnt_ff - ev.counter;
   assign dt        = ev.time_val - prev_time_ff;

   // classify the event and update sequence state at the pop
   always_comb begin
      prev_cnt_in   = prev_cnt_ff;
      prev_time_in  = prev_time_ff;
      seen_first_in = seen_first_ff;
      perfect_in    = perfect_ff;
      s1_rsp_in     = '0;
      s1_back_in    = back_diff;
      s1_check_in   = 1'b0;
      s1_rsp_in.garbage_bytes = ev.garbage;
      case (ev.kind)
         tfc_pkg::EV_FRAME: begin
            s1_rsp_in.counter_value = ev.counter;
            s1_rsp_in.frame_length  = ev.length;
            if (ev.flag) begin
               s1_rsp_in.status = tfc_pkg::ST_GOOD;
               if ((prev_cnt_ff == '0) || (prev_inc == ev.counter)) begin
                  s1_rsp_in.seq_class = tfc_pkg::CLS_IN_ORDER;
               end else if (prev_cnt_ff == ev.counter) begin
                  s1_rsp_in.seq_class = tfc_pkg::CLS_DUPLICATE;
                  perfect_in = 1'b0;
               end else if (ev.counter < prev_cnt_ff) begin
                  // refined into reboot in the next stage
                  s1_rsp_in.seq_class = tfc_pkg::CLS_OUT_OF_SEQ;
               end else begin
                  s1_rsp_in.seq_class     = tfc_pkg::CLS_GAP;
                  s1_rsp_in.missing_count = fwd_miss;
                  perfect_in = 1'b0;
               end
               if (seen_first_ff) begin
                  s1_rsp_in.time_delta = dt;
                  s1_check_in = 1'b1;
               end
               prev_time_in  = ev.time_val;
               prev_cnt_in   = ev.counter;
               seen_first_in = 1'b1;
            end else begin
               s1_rsp_in.status = tfc_pkg::ST_BAD_CHECKSUM;
            end
            s1_rsp_in.all_good = perfect_in;
         end
         tfc_pkg::EV_BAD_VERSION: begin
            s1_rsp_in.status   = tfc_pkg::ST_BAD_VERSION;
            perfect_in         = 1'b0;
            s1_rsp_in.all_good = 1'b0;
         end
         tfc_pkg::EV_BAD_LENGTH: begin
            s1_rsp_in.status       = tfc_pkg::ST_BAD_LENGTH;
            s1_rsp_in.frame_length = ev.length;
            perfect_in             = 1'b0;
            s1_rsp_in.all_good     = 1'b0;
         end
         tfc_pkg::EV_END: begin
            s1_rsp_in.status = ev.flag ? tfc_pkg::ST_CLEAN_END : tfc_pkg::ST_TRUNC_END;
            s1_rsp_in.counter_value = prev_cnt_ff;
            s1_rsp_in.frame_length  = ev.length;
            s1_rsp_in.all_good      = ev.flag & perfect_ff;
            prev_cnt_in   = '0;
            prev_time_in  = '0;
            seen_first_in = 1'b0;
            perfect_in    = 1'b1;
         end
         default: begin
            s1_rsp_in.status = tfc_pkg::ST_BAD_VERSION;
         end
      endcase
      if (!ev_pop) begin
         prev_cnt_in   = prev_cnt_ff;
         prev_time_in  = prev_time_ff;
         seen_first_in = seen_first_ff;
         perfect_in    = perfect_ff;
      end
      s1_valid_in = s1_ready ? ev_pop : s1_valid_ff;
   end

   // threshold compares against configuration
   always_comb begin
      rsp = s1_rsp_ff;
      if ((s1_rsp_ff.seq_class == tfc_pkg::CLS_OUT_OF_SEQ) &&
          (s1_back_ff >= cfg.reboot_threshold)) begin
         rsp.seq_class = tfc_pkg::CLS_REBOOT;
      end
      rsp.time_irregular = s1_check_ff &&
                           ((s1_rsp_ff.time_delta < cfg.time_step_min) ||
                            (s1_rsp_ff.time_delta > cfg.time_step_max));
   end

   assign rsp_valid = s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_cnt_ff   <= '0;
         prev_time_ff  <= '0;
         seen_first_ff <= 1'b0;
         perfect_ff    <= 1'b1;
         s1_valid_ff   <= 1'b0;
      end else begin
         prev_cnt_ff   <= prev_cnt_in;
         prev_time_ff  <= prev_time_in;
         seen_first_ff <= seen_first_in;
         perfect_ff    <= perfect_in;
         s1_valid_ff   <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ev_pop) begin
         s1_rsp_ff   <= s1_rsp_in;
         s1_back_ff  <= s1_back_in;
         s1_check_ff <= s1_check_in;
      end
   end

endmodule

// File: dv/tb_top.sv
module tb_top;

   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 16;

   typedef enum logic [2:0] {
      SEEK_SYNC = 3'b001,
      SEEK_X    = 3'b010,
      IN_FRAME  = 3'b100
   } scan_phase_type;

   // one entry of the capture stream: a byte, an end mark or a register write
   typedef struct packed {
      logic                   is_reg;
      logic                   burst;
      logic                   end_mark;
      logic [7:0]             data;
      tfc_pkg::csr_index_type reg_index;
      logic [31:0]            reg_value;
   } capture_item_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   push = 1'b0;
   logic                   full;
   logic [7:0]             req_data_byte = 8'd0;
   logic                   req_end_mark = 1'b0;
   logic                   empty;
   logic                   pop = 1'b0;
   logic [2:0]             rsp_status;
   logic [2:0]             rsp_seq_class;
   logic [31:0]            rsp_counter_value;
   logic [31:0]            rsp_missing_count;
   logic [31:0]            rsp_time_delta;
   logic                   rsp_time_irregular;
   logic [15:0]            rsp_garbage_bytes;
   logic [15:0]            rsp_frame_length;
   logic                   rsp_all_good;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   tfc_pkg::csr_index_type csr_index = tfc_pkg::CSR_VERSION;
   logic [31:0]            csr_data = 32'd0;

   capture_item_type  capture_q[$];
   tfc_pkg::rsp_type  expected_reports[$];
   int                mismatches = 0;

   // checker state
   tfc_pkg::cfg_type regs;
   scan_phase_type   scan_phase;
   logic [15:0]      frame_pos;
   logic [15:0]      frame_len;
   logic [15:0]      skip_run;
   logic [31:0]      byte_sum;
   logic [31:0]      frame_stamp;
   logic [31:0]      frame_cnt;
   logic [31:0]      claimed_sum;
   logic [31:0]      last_cnt;
   logic [31:0]      last_stamp;
   logic             seen_good;
   logic             clean_so_far;

   // stimulus generator view of the configuration and sequence
   logic [7:0]  gen_ver = tfc_pkg::VERSION_RST;
   logic [31:0] gen_min = tfc_pkg::STEP_MIN_RST;
   logic [31:0] gen_max = tfc_pkg::STEP_MAX_RST;
   logic [31:0] gen_reboot = tfc_pkg::REBOOT_RST;
   logic [31:0] gen_cnt = 32'd0;
   logic [31:0] gen_stamp = 32'd0;

   int send_gap = 0;
   bit send_calm = 1'b0;
   int take_gap = 0;
   bit take_calm = 1'b0;
   int idle_cycles = 0;

   telegram_frame_checker dut (
      .clock,
      .reset,
      .push,
      .full,
      .req_data_byte,
      .req_end_mark,
      .empty,
      .pop,
      .rsp_status,
      .rsp_seq_class,
      .rsp_counter_value,
      .rsp_missing_count,
      .rsp_time_delta,
      .rsp_time_irregular,
      .rsp_garbage_bytes,
      .rsp_frame_length,
      .rsp_all_good,
      .csr_valid,
      .csr_ready,
      .csr_index,
      .csr_data
   );

   always #4 clock = ~clock;

   function automatic void clear_sequence();
      scan_phase   = SEEK_SYNC;
      frame_pos    = 16'd0;
      frame_len    = 16'd0;
      skip_run     = 16'd0;
      byte_sum     = 32'd0;
      frame_stamp  = 32'd0;
      frame_cnt    = 32'd0;
      claimed_sum  = 32'd0;
      last_cnt     = 32'd0;
      last_stamp   = 32'd0;
      seen_good    = 1'b0;
      clean_so_far = 1'b1;
   endfunction

   function automatic void resume_hunt();
      scan_phase = SEEK_SYNC;
      frame_pos  = 16'd0;
      skip_run   = 16'd0;
   endfunction

   function automatic void bump_skip(input int n);
      skip_run = ({1'b0, skip_run} + n > tfc_pkg::SKIP_MAX) ? tfc_pkg::SKIP_MAX
                                                             : skip_run + 16'(n);
   endfunction

   function automatic tfc_pkg::rsp_type make_report(input tfc_pkg::status_type st,
                                                    input tfc_pkg::class_type cls,
                                                    input logic [31:0] cnt,
                                                    input logic [31:0] miss,
                                                    input logic [31:0] dt, input logic irr,
                                                    input logic [15:0] len);
      tfc_pkg::rsp_type rep;
      rep.status         = st;
      rep.seq_class      = cls;
      rep.counter_value  = cnt;
      rep.missing_count  = miss;
      rep.time_delta     = dt;
      rep.time_irregular = irr;
      rep.garbage_bytes  = skip_run;
      rep.frame_length   = len;
      rep.all_good       = clean_so_far;
      return rep;
   endfunction

   // Advance the checker by one capture entry; returns 1 when a report is due.
   function automatic bit parse_capture_byte(input logic [7:0] b, input logic end_mark,
                                             output tfc_pkg::rsp_type rep);
      logic [31:0]        pos32;
      logic [15:0]        len_out;
      bit                 clean;
      tfc_pkg::class_type cls;
      logic [31:0]        miss;
      logic [31:0]        dt;
      logic               irr;
      rep = '0;
      if (end_mark) begin
         clean = scan_phase == SEEK_SYNC && skip_run == 16'd0;
         if (!clean) clean_so_far = 1'b0;
         len_out = (scan_phase == IN_FRAME && frame_pos > tfc_pkg::POS_LEN_LO) ? frame_len
                                                                               : 16'd0;
         rep = make_report(clean ? tfc_pkg::ST_CLEAN_END : tfc_pkg::ST_TRUNC_END,
                           tfc_pkg::CLS_IN_ORDER, last_cnt, 32'd0, 32'd0, 1'b0, len_out);
         clear_sequence();
         return 1'b1;
      end
      if (scan_phase == SEEK_SYNC) begin
         if (b == tfc_pkg::SYNC_I) scan_phase = SEEK_X;
         else bump_skip(1);
         return 1'b0;
      end
      if (scan_phase == SEEK_X) begin
         if (b == tfc_pkg::SYNC_X) begin
            scan_phase  = IN_FRAME;
            frame_pos   = tfc_pkg::POS_VERSION;
            byte_sum    = 32'(tfc_pkg::SYNC_I) + 32'(tfc_pkg::SYNC_X);
            frame_len   = 16'd0;
            frame_stamp = 32'd0;
            frame_cnt   = 32'd0;
            claimed_sum = 32'd0;
         end else if (b == tfc_pkg::SYNC_I) begin
            bump_skip(1);
         end else begin
            bump_skip(2);
            scan_phase = SEEK_SYNC;
         end
         return 1'b0;
      end
      pos32 = {16'd0, frame_pos};
      if (pos32 < tfc_pkg::HDR_LEN || pos32 + 4 < frame_len) byte_sum += b;
      else claimed_sum = {claimed_sum[23:0], b};
      if (frame_pos == tfc_pkg::POS_VERSION && b != regs.expected_version) begin
         clean_so_far = 1'b0;
         rep = make_report(tfc_pkg::ST_BAD_VERSION, tfc_pkg::CLS_IN_ORDER, 32'd0, 32'd0,
                           32'd0, 1'b0, 16'd0);
         resume_hunt();
         return 1'b1;
      end
      if (frame_pos == tfc_pkg::POS_LEN_HI || frame_pos == tfc_pkg::POS_LEN_LO)
         frame_len = {frame_len[7:0], b};
      if (frame_pos == tfc_pkg::POS_LEN_LO && frame_len < tfc_pkg::MIN_LEN) begin
         clean_so_far = 1'b0;
         rep = make_report(tfc_pkg::ST_BAD_LENGTH, tfc_pkg::CLS_IN_ORDER, 32'd0, 32'd0,
                           32'd0, 1'b0, frame_len);
         resume_hunt();
         return 1'b1;
      end
      if (frame_pos >= tfc_pkg::POS_TIME_FIRST && frame_pos <= tfc_pkg::POS_TIME_LAST)
         frame_stamp = {frame_stamp[23:0], b};
      if (frame_pos >= tfc_pkg::POS_CNT_FIRST && frame_pos <= tfc_pkg::POS_CNT_LAST)
         frame_cnt = {frame_cnt[23:0], b};
      if (frame_pos >= tfc_pkg::HDR_LEN && pos32 + 1 == frame_len) begin
         if (byte_sum != claimed_sum) begin
            rep = make_report(tfc_pkg::ST_BAD_CHECKSUM, tfc_pkg::CLS_IN_ORDER, frame_cnt,
                              32'd0, 32'd0, 1'b0, frame_len);
         end else begin
            miss = 32'd0;
            dt   = 32'd0;
            irr  = 1'b0;
            if (last_cnt == 32'd0 || last_cnt + 32'd1 == frame_cnt) begin
               cls = tfc_pkg::CLS_IN_ORDER;
            end else if (last_cnt == frame_cnt) begin
               cls = tfc_pkg::CLS_DUPLICATE;
               clean_so_far = 1'b0;
            end else if (frame_cnt < last_cnt) begin
               cls = (last_cnt - frame_cnt < regs.reboot_threshold) ? tfc_pkg::CLS_OUT_OF_SEQ
                                                                    : tfc_pkg::CLS_REBOOT;
            end else begin
               cls  = tfc_pkg::CLS_GAP;
               miss = frame_cnt - last_cnt - 32'd1;
               clean_so_far = 1'b0;
            end
            if (seen_good) begin
               dt  = frame_stamp - last_stamp;
               irr = dt < regs.time_step_min || dt > regs.time_step_max;
            end
            last_stamp = frame_stamp;
            last_cnt   = frame_cnt;
            seen_good  = 1'b1;
            rep = make_report(tfc_pkg::ST_GOOD, cls, frame_cnt, miss, dt, irr, frame_len);
         end
         resume_hunt();
         return 1'b1;
      end
      frame_pos = frame_pos + 16'd1;
      return 1'b0;
   endfunction

   task automatic add_byte(input logic [7:0] b, input bit burst = 1'b0);
      capture_item_type item;
      item       = '0;
      item.data  = b;
      item.burst = burst;
      capture_q.push_back(item);
   endtask

   task automatic add_end();
      capture_item_type item;
      item          = '0;
      item.data     = 8'($urandom());
      item.end_mark = 1'b1;
      capture_q.push_back(item);
   endtask

   task automatic add_reg(input tfc_pkg::csr_index_type idx, input logic [31:0] val);
      capture_item_type item;
      item           = '0;
      item.is_reg    = 1'b1;
      item.reg_index = idx;
      item.reg_value = val;
      capture_q.push_back(item);
      case (idx)
         tfc_pkg::CSR_VERSION:  gen_ver = val[7:0];
         tfc_pkg::CSR_STEP_MIN: gen_min = val;
         tfc_pkg::CSR_STEP_MAX: gen_max = val;
         tfc_pkg::CSR_REBOOT:   gen_reboot = val;
         default: ;
      endcase
   endtask

   // Skipped bytes: never an 'X', so no sync forms by accident.
   task automatic add_junk(input int n, input bit burst = 1'b0);
      logic [7:0] b;
      repeat (n) begin
         b = ($urandom_range(0, 3) == 0) ? tfc_pkg::SYNC_I : 8'($urandom());
         if (b == tfc_pkg::SYNC_X) b = 8'h00;
         add_byte(b, burst);
      end
   endtask

   // Build a telegram with a correct claim (unless corrupted or len is below MIN_LEN); emit only the
   // first cut bytes when cut is not negative.
   task automatic add_frame(input logic [7:0] ver, input logic [15:0] len,
                            input logic [31:0] stamp, input logic [31:0] count,
                            input bit corrupt = 1'b0, input int cut = -1,
                            input bit burst = 1'b0);
      logic [7:0]  fb[];
      logic [31:0] sum;
      int          n;
      int          upto;
      n  = (len >= tfc_pkg::MIN_LEN) ? int'(len) : int'(tfc_pkg::HDR_LEN);
      fb = new[n];
      foreach (fb[i]) fb[i] = 8'($urandom());
      fb[0]  = tfc_pkg::SYNC_I;
      fb[1]  = tfc_pkg::SYNC_X;
      fb[2]  = ver;
      fb[17] = len[15:8];
      fb[18] = len[7:0];
      for (int i = 0; i < 4; i++) begin
         fb[19 + i] = stamp[31 - 8 * i -: 8];
         fb[23 + i] = count[31 - 8 * i -: 8];
      end
      sum = 32'd0;
      for (int i = 0; i < n - 4; i++) sum += fb[i];
      if (corrupt) sum += $urandom_range(1, 255);
      if (len >= tfc_pkg::MIN_LEN) begin
         for (int i = 0; i < 4; i++) fb[n - 4 + i] = sum[31 - 8 * i -: 8];
      end
      upto = (cut < 0 || cut > n) ? n : cut;
      for (int i = 0; i < upto; i++) add_byte(fb[i], burst);
   endtask

   task automatic add_random_traffic(input int byte_goal);
      int          start_len;
      int          made;
      int          kind;
      int          r;
      logic [31:0] count;
      logic [31:0] step;
      logic [15:0] len;
      logic [7:0]  flip;
      start_len = capture_q.size();
      made = 0;
      while (capture_q.size() - start_len < byte_goal || made < 4) begin
         kind = $urandom_range(0, 99);
         if ($urandom_range(0, 3) == 0) add_junk($urandom_range(1, 4));
         if (kind < 55) begin
            r = $urandom_range(0, 99);
            if (r < 55) count = gen_cnt + 32'd1;
            else if (r < 65) count = gen_cnt;
            else if (r < 75) count = gen_cnt + $urandom_range(2, 1000);
            else if (r < 82) count = gen_cnt - $urandom_range(1, 300);
            else if (r < 86) count = gen_cnt - gen_reboot;
            else if (r < 90) count = gen_cnt - gen_reboot + 32'd1;
            else count = $urandom();
            r = $urandom_range(0, 9);
            if (r < 6) step = $urandom_range(gen_min, gen_max);
            else if (r == 6) step = gen_min - 32'd1;
            else if (r == 7) step = gen_max + 32'd1;
            else step = $urandom();
            gen_stamp += step;
            gen_cnt = count;
            len = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(49, 400))
                                               : 16'($urandom_range(31, 44));
            add_frame(gen_ver, len, gen_stamp, count, $urandom_range(0, 9) == 0);
         end else if (kind < 63) begin
            flip = 8'($urandom_range(1, 255));
            add_frame(gen_ver ^ flip, 16'd31, $urandom(), $urandom(), 1'b0, 3);
         end else if (kind < 71) begin
            len = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 30));
            add_frame(gen_ver, len, $urandom(), $urandom(), 1'b0, 19);
         end else if (kind < 79) begin
            add_frame(gen_ver, 16'($urandom_range(31, 60)), $urandom(), $urandom(), 1'b0,
                      $urandom_range(1, 30));
            add_end();
            gen_cnt = 32'd0;
         end else if (kind < 87) begin
            add_end();
            gen_cnt = 32'd0;
         end else if (kind < 95) begin
            add_junk($urandom_range(1, 8));
         end else begin
            // raw noise may open a frame anywhere; close the capture after it
            repeat ($urandom_range(1, 20)) add_byte(8'($urandom()));
            add_end();
            gen_cnt = 32'd0;
         end
         if (kind < 87 || kind >= 95) made++;
      end
   endtask

   // input side: drive the capture stream and predict on every transfer
   always @(posedge clock) begin : drive_capture
      capture_item_type head;
      logic             nxt_push;
      logic             nxt_csr;
      tfc_pkg::rsp_type rep;
      if (reset) begin
         push      <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         nxt_push = push;
         nxt_csr  = csr_valid;
         if (push && !full) begin
            head = capture_q.pop_front();
            if (parse_capture_byte(head.data, head.end_mark, rep))
               expected_reports.push_back(rep);
            nxt_push = 1'b0;
            send_gap = (head.burst || send_calm) ? 0 : $urandom_range(0, 17);
            if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
         end
         if (csr_valid && csr_ready) begin
            head = capture_q.pop_front();
            case (head.reg_index)
               tfc_pkg::CSR_VERSION:  regs.expected_version = head.reg_value[7:0];
               tfc_pkg::CSR_STEP_MIN: regs.time_step_min = head.reg_value;
               tfc_pkg::CSR_STEP_MAX: regs.time_step_max = head.reg_value;
               tfc_pkg::CSR_REBOOT:   regs.reboot_threshold = head.reg_value;
               default: ;
            endcase
            nxt_csr = 1'b0;
            idle_cycles = 0;
         end
         if (!nxt_push && !nxt_csr && capture_q.size() != 0) begin
            head = capture_q[0];
            if (head.is_reg) begin
               // hold the write until every report is out and the pipe is quiet
               if (expected_reports.size() == 0) idle_cycles++;
               else idle_cycles = 0;
               if (idle_cycles >= SETTLE_CYCLES) begin
                  csr_index <= head.reg_index;
                  csr_data  <= head.reg_value;
                  nxt_csr = 1'b1;
               end
            end else if (send_gap != 0) begin
               send_gap--;
            end else begin
               req_data_byte <= head.data;
               req_end_mark  <= head.end_mark;
               nxt_push = 1'b1;
            end
         end
         push      <= nxt_push;
         csr_valid <= nxt_csr;
      end
   end

   task automatic compare_field(input string name, input logic [31:0] want_v,
                                input logic [31:0] got_v);
      if (want_v !== got_v) begin
         mismatches++;
         if (mismatches <= 10)
            $display("report field %s: expected %0h, got %0h", name, want_v, got_v);
      end
   endtask

   // result side: pop with random stalls and check against the predicted reports
   always @(posedge clock) begin : check_reports
      tfc_pkg::rsp_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected report: status %0d counter %0h",
                           rsp_status, rsp_counter_value);
            end else begin
               want = expected_reports.pop_front();
               compare_field("status", 32'(want.status), 32'(rsp_status));
               compare_field("seq_class", 32'(want.seq_class), 32'(rsp_seq_class));
               compare_field("counter_value", want.counter_value, rsp_counter_value);
               compare_field("missing_count", want.missing_count, rsp_missing_count);
               compare_field("time_delta", want.time_delta, rsp_time_delta);
               compare_field("time_irregular", 32'(want.time_irregular),
                             32'(rsp_time_irregular));
               compare_field("garbage_bytes", 32'(want.garbage_bytes),
                             32'(rsp_garbage_bytes));
               compare_field("frame_length", 32'(want.frame_length), 32'(rsp_frame_length));
               compare_field("all_good", 32'(want.all_good), 32'(rsp_all_good));
            end
            take_gap = take_calm ? 0 : $urandom_range(0, 17);
            if ($urandom_range(0, 49) == 0) take_calm = !take_calm;
         end
         if (take_gap != 0) begin
            take_gap--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   initial begin
      regs.expected_version = tfc_pkg::VERSION_RST;
      regs.time_step_min    = tfc_pkg::STEP_MIN_RST;
      regs.time_step_max    = tfc_pkg::STEP_MAX_RST;
      regs.reboot_threshold = tfc_pkg::REBOOT_RST;
      clear_sequence();

      add_end();
      add_frame(tfc_pkg::VERSION_RST, 16'd31, 32'd1000, 32'd7);
      add_frame(tfc_pkg::VERSION_RST, 16'd31, 32'd1050, 32'd8);
      add_frame(tfc_pkg::VERSION_RST, 16'd33, 32'd1101, 32'd8);   // duplicate
      add_frame(tfc_pkg::VERSION_RST, 16'd31, 32'd1150, 32'd12);  // gap, step too short
      add_frame(tfc_pkg::VERSION_RST, 16'd31, 32'd1202, 32'd10);  // out of sequence, step too long
      add_frame(tfc_pkg::VERSION_RST, 16'd31, 32'd1252, 32'd500);
      add_frame(tfc_pkg::VERSION_RST, 16'd31, 32'd1302, 32'd400); // back by exactly the threshold
      add_frame(tfc_pkg::VERSION_RST, 16'd31, 32'd1352, 32'd301); // back by one less
      add_frame(tfc_pkg::VERSION_RST, 16'd36, 32'd1402, 32'd302, 1'b1);
      add_frame(8'd6, 16'd31, 32'd0, 32'd0, 1'b0, 3);
      add_frame(tfc_pkg::VERSION_RST, 16'd30, 32'd0, 32'd0, 1'b0, 19);
      add_frame(tfc_pkg::VERSION_RST, 16'd0, 32'd0, 32'd0, 1'b0, 19);
      // lone sync starts ahead of a real one
      add_byte(tfc_pkg::SYNC_I);
      add_byte(8'h00);
      add_byte(tfc_pkg::SYNC_I);
      add_frame(tfc_pkg::VERSION_RST, 16'd64, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
      add_frame(tfc_pkg::VERSION_RST, 16'd31, 32'h0000_0022, 32'd0);  // counter and time wrap
      add_frame(tfc_pkg::VERSION_RST, 16'd31, 32'h0000_0054, 32'd0);
      add_frame(tfc_pkg::VERSION_RST, 16'd40, 32'd0, 32'd0, 1'b0, 20);
      add_end();
      add_byte(tfc_pkg::SYNC_I);
      add_end();
      add_end();
      add_junk(3);
      add_end();
      // back-to-back burst of skipped bytes, then a long telegram
      add_junk(20, 1'b1);
      add_frame(tfc_pkg::VERSION_RST, 16'd120, 32'd77, 32'd303, 1'b0, -1, 1'b1);
      add_end();

      add_reg(tfc_pkg::CSR_VERSION, 32'd0);
      add_reg(tfc_pkg::CSR_STEP_MIN, 32'd0);
      add_reg(tfc_pkg::CSR_STEP_MAX, 32'hFFFF_FFFF);
      add_reg(tfc_pkg::CSR_REBOOT, 32'd1);
      add_random_traffic(200);

      add_reg(tfc_pkg::CSR_VERSION, 32'hFFFF_FFFF);
      add_reg(tfc_pkg::CSR_STEP_MIN, 32'hFFFF_FFFF);
      add_reg(tfc_pkg::CSR_STEP_MAX, 32'd0);
      add_reg(tfc_pkg::CSR_REBOOT, 32'hFFFF_FFFF);
      add_random_traffic(200);

      add_reg(tfc_pkg::CSR_VERSION, $urandom());
      add_reg(tfc_pkg::CSR_STEP_MIN, $urandom_range(0, 200));
      add_reg(tfc_pkg::CSR_STEP_MAX, gen_min + $urandom_range(0, 100));
      add_reg(tfc_pkg::CSR_REBOOT, $urandom_range(1, 500));
      add_random_traffic(200);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (capture_q.size() != 0 || expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("telegram_frame_checker: match");
      end else begin
         $display("telegram_frame_checker: mismatch");
      end
      $finish;
   end

   initial begin
      #16_000_000;
      $display("telegram_frame_checker: mismatch");
      $finish;
   end

endmodule
